>>> rtl/core/dv3_pkg.sv
// Shared types and constants for the 3-D divergence stream block.
package dv3_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int OUT_BITS    = SAMPLE_BITS + 3;

   localparam int DEF_MAX_FAST = 128;
   localparam int DEF_MAX_MID  = 128;
   localparam int DEF_MAX_SLOW = 1024;

   localparam int LEN_RESET = 128;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int LEN_FM_W   = 8;
   localparam int LEN_S_W    = 11;

   localparam logic [CSR_IDX_W-1:0] REG_LEN_FAST = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEN_MID  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEN_SLOW = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] comp_fast;
      logic signed [SAMPLE_BITS-1:0] comp_mid;
      logic signed [SAMPLE_BITS-1:0] comp_slow;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] div_value;
      logic                       volume_end;
   } rsp_type;

endpackage

>>> rtl/core/divergence_3d_stream.sv
// Streaming backward-difference divergence of a 3-D vector field.
//
// Usage: voxels enter on the req_ channel in raster order, fast axis first,
// then middle, then slow; each item carries the three field components.
// Every input item gives exactly one result item on the rsp_ channel, the
// divergence at that voxel, with volume_end set on the last voxel.
// Both channels use valid/ready; the csr_ port sets the three axis lengths,
// and any write to a known register restarts the volume at position zero.
// An accepted item passes through the input stage and then the result
// register before it is offered on rsp_. Throughput is one item per cycle
// while rsp_ready is high, set by the single-ported row and plane memories,
// read, then written at the same address in the cycle an item is accepted.
// Reset sets each length to 128, or its axis maximum if smaller, and the
// position to the volume start; the row and plane memories are not cleared,
// since every entry is written in a volume before it is read.
// When the receiver stalls, the input stage and the result register each
// hold one item; req_ready drops only when both are full.
module divergence_3d_stream
   import dv3_pkg::*;
#(
   parameter int MAX_FAST = DEF_MAX_FAST,
   parameter int MAX_MID  = DEF_MAX_MID,
   parameter int MAX_SLOW = DEF_MAX_SLOW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int LF_W        = $clog2(MAX_FAST + 1);
   localparam int LM_W        = $clog2(MAX_MID + 1);
   localparam int LS_W        = $clog2(MAX_SLOW + 1);
   localparam int PF_W        = $clog2(MAX_FAST);
   localparam int PM_W        = $clog2(MAX_MID);
   localparam int PS_W        = $clog2(MAX_SLOW);
   localparam int PLANE_DEPTH = MAX_FAST * MAX_MID;
   localparam int PA_W        = $clog2(PLANE_DEPTH);
   localparam int TERM_W      = SAMPLE_BITS + 1;

   localparam int RST_F = (LEN_RESET < MAX_FAST) ? LEN_RESET : MAX_FAST;
   localparam int RST_M = (LEN_RESET < MAX_MID) ? LEN_RESET : MAX_MID;
   localparam int RST_S = (LEN_RESET < MAX_SLOW) ? LEN_RESET : MAX_SLOW;

   // Configuration and position state.
   logic [LF_W-1:0] len_fast_ff, len_fast_in;
   logic [LM_W-1:0] len_mid_ff, len_mid_in;
   logic [LS_W-1:0] len_slow_ff, len_slow_in;
   logic [PF_W-1:0] pos_fast_ff, pos_fast_in;
   logic [PM_W-1:0] pos_mid_ff, pos_mid_in;
   logic [PS_W-1:0] pos_slow_ff, pos_slow_in;
   logic [PA_W-1:0] plane_addr_ff, plane_addr_in;
   logic signed [SAMPLE_BITS-1:0] prev_fast_ff;

   // Stage A: input register plus the registered memory reads.
   logic                          a_valid_ff, a_valid_in;
   logic signed [TERM_W-1:0]      a_fast_term_ff;
   logic signed [SAMPLE_BITS-1:0] a_comp_mid_ff;
   logic signed [SAMPLE_BITS-1:0] a_comp_slow_ff;
   logic                          a_first_m_ff, a_last_m_ff;
   logic                          a_first_s_ff, a_last_s_ff;
   logic                          a_vend_ff;
   logic signed [SAMPLE_BITS-1:0] row_rd_ff;
   logic signed [SAMPLE_BITS-1:0] plane_rd_ff;

   // Stage B: result register.
   logic    b_valid_ff, b_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic signed [SAMPLE_BITS-1:0] row_mem [MAX_FAST];
   logic signed [SAMPLE_BITS-1:0] plane_mem [PLANE_DEPTH];

   logic req_accept, a_advance, b_free;
   logic first_f, first_m, first_s;
   logic last_f, last_m, last_s;
   logic signed [TERM_W-1:0] fast_term, mid_term, slow_term;
   logic signed [TERM_W-1:0] cur_f, prv_f, cur_m, prv_m, cur_s, prv_s;

   logic [LEN_FM_W-1:0] wr_fm;
   logic [LEN_S_W-1:0]  wr_s;

   assign b_free     = !b_valid_ff || rsp_ready;
   assign a_advance  = a_valid_ff && b_free;
   assign req_ready  = !a_valid_ff || b_free;
   assign req_accept = req_valid && req_ready;

   assign rsp_valid = b_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign wr_fm = csr_wdata[LEN_FM_W-1:0];
   assign wr_s  = csr_wdata[LEN_S_W-1:0];

   assign first_f = (pos_fast_ff == '0);
   assign first_m = (pos_mid_ff == '0);
   assign first_s = (pos_slow_ff == '0);
   assign last_f  = (LF_W'(pos_fast_ff) + LF_W'(1)) == len_fast_ff;
   assign last_m  = (LM_W'(pos_mid_ff) + LM_W'(1)) == len_mid_ff;
   assign last_s  = (LS_W'(pos_slow_ff) + LS_W'(1)) == len_slow_ff;

   // Fast-axis term is formed at the input; its previous value is a register.
   always_comb begin
      cur_f = TERM_W'(req_data.comp_fast);
      prv_f = TERM_W'(prev_fast_ff);
      if (first_f) begin
         fast_term = cur_f;
      end else if (last_f) begin
         fast_term = -prv_f;
      end else begin
         fast_term = cur_f - prv_f;
      end
   end

   always_comb begin
      cur_m = TERM_W'(a_comp_mid_ff);
      prv_m = TERM_W'(row_rd_ff);
      cur_s = TERM_W'(a_comp_slow_ff);
      prv_s = TERM_W'(plane_rd_ff);
      if (a_first_m_ff) begin
         mid_term = cur_m;
      end else if (a_last_m_ff) begin
         mid_term = -prv_m;
      end else begin
         mid_term = cur_m - prv_m;
      end
      if (a_first_s_ff) begin
         slow_term = cur_s;
      end else if (a_last_s_ff) begin
         slow_term = -prv_s;
      end else begin
         slow_term = cur_s - prv_s;
      end
      rsp_data_in.div_value  = OUT_BITS'(a_fast_term_ff) + OUT_BITS'(mid_term)
                               + OUT_BITS'(slow_term);
      rsp_data_in.volume_end = a_vend_ff;
   end

   // Lengths, positions and the plane address counter.
   always_comb begin
      len_fast_in   = len_fast_ff;
      len_mid_in    = len_mid_ff;
      len_slow_in   = len_slow_ff;
      pos_fast_in   = pos_fast_ff;
      pos_mid_in    = pos_mid_ff;
      pos_slow_in   = pos_slow_ff;
      plane_addr_in = plane_addr_ff;
      if (csr_we) begin
         case (csr_index)
            REG_LEN_FAST: begin
               if (wr_fm == '0) begin
                  len_fast_in = LF_W'(1);
               end else if (32'(wr_fm) > MAX_FAST) begin
                  len_fast_in = LF_W'(MAX_FAST);
               end else begin
                  len_fast_in = LF_W'(wr_fm);
               end
            end
            REG_LEN_MID: begin
               if (wr_fm == '0) begin
                  len_mid_in = LM_W'(1);
               end else if (32'(wr_fm) > MAX_MID) begin
                  len_mid_in = LM_W'(MAX_MID);
               end else begin
                  len_mid_in = LM_W'(wr_fm);
               end
            end
            REG_LEN_SLOW: begin
               if (wr_s == '0) begin
                  len_slow_in = LS_W'(1);
               end else if (32'(wr_s) > MAX_SLOW) begin
                  len_slow_in = LS_W'(MAX_SLOW);
               end else begin
                  len_slow_in = LS_W'(wr_s);
               end
            end
            default: ;
         endcase
         if (csr_index inside {REG_LEN_FAST, REG_LEN_MID, REG_LEN_SLOW}) begin
            pos_fast_in   = '0;
            pos_mid_in    = '0;
            pos_slow_in   = '0;
            plane_addr_in = '0;
         end
      end else if (req_accept) begin
         // The plane store is addressed by a running count within the plane,
         // which gives each (mid, fast) position the same entry every plane.
         if (last_f && last_m) begin
            plane_addr_in = '0;
         end else begin
            plane_addr_in = plane_addr_ff + PA_W'(1);
         end
         if (!last_f) begin
            pos_fast_in = pos_fast_ff + PF_W'(1);
         end else begin
            pos_fast_in = '0;
            if (!last_m) begin
               pos_mid_in = pos_mid_ff + PM_W'(1);
            end else begin
               pos_mid_in = '0;
               if (!last_s) begin
                  pos_slow_in = pos_slow_ff + PS_W'(1);
               end else begin
                  pos_slow_in = '0;
               end
            end
         end
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_accept) begin
         a_valid_in = 1'b1;
      end else if (a_advance) begin
         a_valid_in = 1'b0;
      end
      b_valid_in = b_valid_ff;
      if (a_advance) begin
         b_valid_in = 1'b1;
      end else if (rsp_ready) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_fast_ff   <= LF_W'(RST_F);
         len_mid_ff    <= LM_W'(RST_M);
         len_slow_ff   <= LS_W'(RST_S);
         pos_fast_ff   <= '0;
         pos_mid_ff    <= '0;
         pos_slow_ff   <= '0;
         plane_addr_ff <= '0;
         prev_fast_ff  <= '0;
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
      end else begin
         len_fast_ff   <= len_fast_in;
         len_mid_ff    <= len_mid_in;
         len_slow_ff   <= len_slow_in;
         pos_fast_ff   <= pos_fast_in;
         pos_mid_ff    <= pos_mid_in;
         pos_slow_ff   <= pos_slow_in;
         plane_addr_ff <= plane_addr_in;
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
         if (req_accept) begin
            prev_fast_ff <= req_data.comp_fast;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_fast_term_ff <= fast_term;
         a_comp_mid_ff  <= req_data.comp_mid;
         a_comp_slow_ff <= req_data.comp_slow;
         a_first_m_ff   <= first_m;
         a_last_m_ff    <= last_m;
         a_first_s_ff   <= first_s;
         a_last_s_ff    <= last_s;
         a_vend_ff      <= last_f && last_m && last_s;
      end
      if (a_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Read-first memories: an item reads the old entry and leaves its own.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         row_rd_ff            <= row_mem[pos_fast_ff];
         row_mem[pos_fast_ff] <= req_data.comp_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         plane_rd_ff              <= plane_mem[plane_addr_ff];
         plane_mem[plane_addr_ff] <= req_data.comp_slow;
      end
   end

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (LF_W'(pos_fast_ff) < len_fast_ff) && (LM_W'(pos_mid_ff) < len_mid_ff)
      && (LS_W'(pos_slow_ff) < len_slow_ff))
      else $error("position counter beyond its axis length");

   a_wrap_at_end: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !csr_we && last_f && last_m && last_s) |=>
      (pos_fast_ff == '0) && (pos_mid_ff == '0) && (pos_slow_ff == '0))
      else $error("position did not wrap after the last voxel");

   a_plane_start: assert property (@(posedge clock) disable iff (reset)
      ((pos_fast_ff == '0) && (pos_mid_ff == '0)) |-> (plane_addr_ff == '0))
      else $error("plane address out of step with position");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !a_advance) |=> (a_valid_ff && $stable(a_fast_term_ff)))
      else $error("stalled item lost from the input stage");

endmodule
